// ===== sv/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multitouch slot tracker
// Holds the per-slot record, command and path state codes, and helpers.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int MAX_SLOTS = 16;

  // Command codes of the input channel.
  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_HELD    = 1'b1;

  // Path state codes, signed three bit.
  localparam logic signed [2:0] PS_MIDDLE = 3'sd0;
  localparam logic signed [2:0] PS_FIRST  = 3'sd1;
  localparam logic signed [2:0] PS_LAST   = 3'sd2;
  localparam logic signed [2:0] PS_NONE   = -3'sd1;

  // Path flag values of a touch packet.
  localparam logic [1:0] FLAGS_FIRST = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [15:0] HELD_RESET    = 16'd2000;

  typedef struct packed {
    logic signed [12:0] cur_x;
    logic signed [12:0] cur_y;
    logic signed [12:0] prev_x;
    logic signed [12:0] prev_y;
    logic signed [13:0] move_x;
    logic signed [13:0] move_y;
    logic signed [2:0]  path_state;
    logic signed [2:0]  prior_state;
    logic [31:0]        start_time;
    logic [31:0]        update_time;
  } slot_rec_t;

  // Clears a slot but keeps its prior state.
  function automatic slot_rec_t clear_rec(input slot_rec_t r);
    slot_rec_t c;
    c = '0;
    c.path_state  = PS_NONE;
    c.prior_state = r.prior_state;
    return c;
  endfunction

  function automatic slot_rec_t reset_rec();
    slot_rec_t c;
    c = '0;
    c.path_state = PS_NONE;
    return c;
  endfunction

endpackage

// ===== sv/multitouch_slot_tracker_core.sv =====
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_core: finger slot tracker of a touch panel
// Updates slot records on touch packets and reports every slot on frame ticks.
// ----------------------------------------------------------------------------
// Usage. Input beats arrive on in_valid/in_ready. A touch packet (cmd 0)
// updates the record of one slot and produces no output beat; a packet
// whose slot is not below min(SLOTS, 16) is dropped. A frame tick (cmd 1)
// walks min(SLOTS, 16) slots in index order and sends one output beat per
// slot on out_valid/out_ready, with last high on the final one. Each slot
// of a tick makes four passes through the shared 32-bit subtract/compare
// unit (idle timeout, held time, x movement, y movement) and one emit step.
// in_ready is low while a tick is being walked. The output beat sits in a
// register, so a new input beat can be taken while the previous result
// still waits; when the receiver stalls, the walk halts at the emit step
// until the register frees. Reset empties every slot, clears the packet
// count and loads the timeout and held times with 3000 and 2000 ms.
// Configuration writes on cfg_we take effect at once and are to be made
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_core import mst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [15:0]        cfg_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [3:0]         slot,
  input  logic [11:0]        pos_x,
  input  logic [11:0]        pos_y,
  input  logic [1:0]         path_flags,
  input  logic [31:0]        now_ms,
  // Output channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         slot_out,
  output logic               pressed,
  output logic               released,
  output logic               down,
  output logic               held,
  output logic signed [13:0] delta_x,
  output logic signed [13:0] delta_y,
  output logic signed [17:0] total_dx,
  output logic signed [17:0] total_dy,
  output logic [4:0]         packet_count,
  output logic               last
);

  // The slot field can name at most sixteen slots.
  localparam int NW = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int IW = $clog2(NW);
  localparam int CW = $clog2(SLOTS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TIME = 3'd1;
  localparam logic [2:0] S_HELD = 3'd2;
  localparam logic [2:0] S_DX   = 3'd3;
  localparam logic [2:0] S_DY   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]         state;
  logic [IW-1:0]      idx;
  logic [31:0]        now_reg;
  logic [15:0]        timeout_ms;
  logic [15:0]        held_ms;
  logic [CW-1:0]      frame_packets;
  logic signed [17:0] tx;
  logic signed [17:0] ty;
  logic               held_r;

  // Record storage.
  logic [IW-1:0] rd_addr;
  slot_rec_t     rec;
  logic          wr_en;
  slot_rec_t     wr_data;

  // Shared unit.
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic [15:0] alu_lim;
  logic [31:0] alu_diff;
  logic        alu_gt;

  logic              in_fire;
  logic              slot_ok;
  logic              emit_go;
  logic              last_slot;
  logic              is_down;
  logic signed [13:0] move_new;
  logic [5:0]        count_ext;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_ok   = {1'b0, slot} < 5'(NW);
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);
  assign last_slot = (idx == IW'(NW - 1));
  assign is_down   = (rec.path_state == PS_MIDDLE);
  assign move_new  = alu_diff[13:0];
  assign count_ext = 6'(frame_packets);

  assign rd_addr = (state == S_IDLE) ? slot[IW-1:0] : idx;

  mst_slot_file #(
    .DEPTH (NW),
    .AW    (IW)
  ) u_slot_file (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rec),
    .wr_en   (wr_en),
    .wr_addr (rd_addr),
    .wr_data (wr_data)
  );

  mst_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .lim  (alu_lim),
    .diff (alu_diff),
    .gt   (alu_gt)
  );

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = now_reg;
    alu_b   = rec.update_time;
    alu_lim = timeout_ms;
    case (state)
      S_TIME: begin
        alu_b   = rec.update_time;
        alu_lim = timeout_ms;
      end
      S_HELD: begin
        alu_b   = rec.start_time;
        alu_lim = held_ms;
      end
      S_DX: begin
        alu_a   = 32'(rec.cur_x);
        alu_b   = 32'(rec.prev_x);
        alu_lim = '0;
      end
      S_DY: begin
        alu_a   = 32'(rec.cur_y);
        alu_b   = 32'(rec.prev_y);
        alu_lim = '0;
      end
      default: begin
        alu_a = now_reg;
      end
    endcase
  end

  // Record updates, one read-modify-write per cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rec;
    case (state)
      S_IDLE: begin
        if (in_fire && (cmd == CMD_TOUCH) && slot_ok) begin
          wr_en               = 1'b1;
          wr_data.prev_x      = rec.cur_x;
          wr_data.prev_y      = rec.cur_y;
          wr_data.cur_x       = $signed({1'b0, pos_x});
          wr_data.cur_y       = $signed({1'b0, pos_y});
          if (path_flags == FLAGS_FIRST) begin
            wr_data.prev_x     = -13'sd1;
            wr_data.prev_y     = -13'sd1;
            wr_data.start_time = now_ms;
          end
          wr_data.update_time = now_ms;
          wr_data.path_state  = $signed({1'b0, path_flags});
        end
      end
      S_TIME: begin
        if (alu_gt) begin
          wr_en   = 1'b1;
          wr_data = clear_rec(rec);
        end
      end
      S_DX: begin
        if (is_down) begin
          wr_en          = 1'b1;
          wr_data.move_x = move_new;
        end
      end
      S_DY: begin
        if (is_down) begin
          wr_en          = 1'b1;
          wr_data.move_y = move_new;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          wr_en = 1'b1;
          if (rec.path_state == PS_LAST) begin
            wr_data = clear_rec(rec);
          end
          wr_data.prior_state = rec.path_state;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
      held_ms    <= HELD_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == REG_TIMEOUT) begin
        timeout_ms <= cfg_data;
      end else begin
        held_ms <= cfg_data;
      end
    end
  end

  // Sequencer and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      frame_packets <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (cmd == CMD_TICK) begin
              state <= S_TIME;
              idx   <= '0;
            end else if (slot_ok && (frame_packets < CW'(SLOTS))) begin
              frame_packets <= frame_packets + 1'b1;
            end
          end
        end
        S_TIME: state <= S_HELD;
        S_HELD: state <= S_DX;
        S_DX:   state <= S_DY;
        S_DY:   state <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            if (last_slot) begin
              state         <= S_IDLE;
              frame_packets <= '0;
            end else begin
              state <= S_TIME;
              idx   <= idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the walk; these need no reset.
  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_TICK)) begin
      now_reg <= now_ms;
      tx      <= '0;
      ty      <= '0;
    end
    if (state == S_HELD) begin
      held_r <= is_down && alu_gt;
    end
    if ((state == S_DX) && is_down) begin
      tx <= tx + 18'(move_new);
    end
    if ((state == S_DY) && is_down) begin
      ty <= ty + 18'(move_new);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      slot_out     <= 4'(idx);
      pressed      <= (rec.path_state == PS_FIRST);
      released     <= (rec.path_state == PS_LAST) && (rec.prior_state <= PS_FIRST);
      down         <= is_down;
      held         <= held_r;
      // A finished path is cleared in this step, so its movement reads zero.
      delta_x      <= (rec.path_state == PS_LAST) ? 14'sd0 : rec.move_x;
      delta_y      <= (rec.path_state == PS_LAST) ? 14'sd0 : rec.move_y;
      total_dx     <= tx;
      total_dy     <= ty;
      packet_count <= count_ext[4:0];
      last         <= last_slot;
    end
  end

endmodule

// ===== sv/mst_alu.sv =====
// ----------------------------------------------------------------------------
// mst_alu: shared subtract and compare unit
// Forms a - b modulo 2^32 and tells whether the difference exceeds a limit.
// ----------------------------------------------------------------------------
module mst_alu import mst_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [15:0] lim,
  output logic [31:0] diff,
  output logic        gt
);

  assign diff = a - b;
  assign gt   = diff > {16'd0, lim};

endmodule

// ===== sv/mst_slot_file.sv =====
// ----------------------------------------------------------------------------
// mst_slot_file: per-slot record storage
// One read address and one write port; every record resets to an empty slot.
// ----------------------------------------------------------------------------
module mst_slot_file import mst_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output slot_rec_t     rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_rec_t     wr_data
);

  slot_rec_t recs [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        recs[i] <= reset_rec();
      end
    end else if (wr_en) begin
      recs[wr_addr] <= wr_data;
    end
  end

  assign rd_data = recs[rd_addr];

endmodule

// ===== dv/multitouch_slot_tracker_core_tb.sv =====
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_core_tb: self-checking bench of the slot tracker
// Drives touch packets and frame ticks with random gaps and output stalls,
// predicts every per-slot report of a tick and compares it field by field.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_core_tb;
  import mst_pkg::*;

  // The block is built with its default slot count; a tick walks all of them.
  localparam int NUM_SLOTS = 16;
  localparam int WALK = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  // Cycles to let pass after the last report before the block counts as idle.
  // A touch packet produces no report, so a short margin is plenty.
  localparam int SETTLE_CYCLES = 10;

  // One report beat of a frame tick, laid out like the output ports.
  typedef struct packed {
    logic [3:0]         slot_out;
    logic               pressed;
    logic               released;
    logic               down;
    logic               held;
    logic signed [13:0] delta_x;
    logic signed [13:0] delta_y;
    logic signed [17:0] total_dx;
    logic signed [17:0] total_dy;
    logic [4:0]         packet_count;
    logic               last;
  } slot_report_t;

  // Keeps a private copy of every slot record and the two time limits, turns
  // each accepted beat into the reports it must cause, and checks arrivals.
  class slot_report_scoreboard;
    slot_rec_t      recs[MAX_SLOTS];
    logic [15:0]    timeout_limit;
    logic [15:0]    held_limit;
    logic [4:0]     frame_packets;
    slot_report_t   expected_reports[$];
    int             errors;

    function new();
      for (int s = 0; s < MAX_SLOTS; s++) begin
        wipe_slot(s);
        recs[s].prior_state = PS_MIDDLE;
      end
      timeout_limit = TIMEOUT_RESET;
      held_limit    = HELD_RESET;
      frame_packets = '0;
      errors        = 0;
    endfunction

    // Empties a slot; the prior state survives on purpose.
    function void wipe_slot(int s);
      logic signed [2:0] keep;
      keep = recs[s].prior_state;
      recs[s] = '0;
      recs[s].path_state  = PS_NONE;
      recs[s].prior_state = keep;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_TIMEOUT) timeout_limit = data;
      else held_limit = data;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_beat(logic op, logic [3:0] slot_i, logic [11:0] x, logic [11:0] y,
                            logic [1:0] flags, logic [31:0] now);
      int                s;
      int                tx;
      int                ty;
      int                dx;
      int                dy;
      logic [31:0]       elapsed;
      logic signed [2:0] st;
      logic [4:0]        count;
      slot_report_t      r;
      s = slot_i;
      if (op == CMD_TOUCH) begin
        if (s >= WALK) return;
        recs[s].prev_x = recs[s].cur_x;
        recs[s].prev_y = recs[s].cur_y;
        recs[s].cur_x  = {1'b0, x};
        recs[s].cur_y  = {1'b0, y};
        if (flags == FLAGS_FIRST) begin
          recs[s].prev_x     = '1;
          recs[s].prev_y     = '1;
          recs[s].start_time = now;
        end
        recs[s].update_time = now;
        recs[s].path_state  = {1'b0, flags};
        if (frame_packets < NUM_SLOTS) frame_packets++;
        return;
      end
      tx = 0;
      ty = 0;
      count = frame_packets;
      for (s = 0; s < WALK; s++) begin
        elapsed = now - recs[s].update_time;
        if (elapsed > timeout_limit) wipe_slot(s);
        st = recs[s].path_state;
        r = '0;
        r.pressed  = (st == PS_FIRST);
        r.released = (st == PS_LAST) && (recs[s].prior_state <= PS_FIRST);
        r.down     = (st == PS_MIDDLE);
        elapsed    = now - recs[s].start_time;
        r.held     = r.down && (elapsed > held_limit);
        if (r.down) begin
          dx = $signed(recs[s].cur_x) - $signed(recs[s].prev_x);
          dy = $signed(recs[s].cur_y) - $signed(recs[s].prev_y);
          recs[s].move_x = dx[13:0];
          recs[s].move_y = dy[13:0];
          tx += $signed(recs[s].move_x);
          ty += $signed(recs[s].move_y);
        end
        recs[s].prior_state = st;
        if (st == PS_LAST) wipe_slot(s);
        r.slot_out     = s[3:0];
        r.delta_x      = recs[s].move_x;
        r.delta_y      = recs[s].move_y;
        r.total_dx     = tx[17:0];
        r.total_dy     = ty[17:0];
        r.packet_count = count;
        r.last         = (s == WALK - 1);
        expected_reports.push_back(r);
      end
      frame_packets = '0;
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(slot_report_t got);
      slot_report_t want;
      if (expected_reports.size() == 0) begin
        $error("report beat for slot %0d arrived with nothing expected", got.slot_out);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("slot_out", want.slot_out, got.slot_out);
      compare_field("pressed", want.pressed, got.pressed);
      compare_field("released", want.released, got.released);
      compare_field("down", want.down, got.down);
      compare_field("held", want.held, got.held);
      compare_field("delta_x", $signed(want.delta_x), $signed(got.delta_x));
      compare_field("delta_y", $signed(want.delta_y), $signed(got.delta_y));
      compare_field("total_dx", $signed(want.total_dx), $signed(got.total_dx));
      compare_field("total_dy", $signed(want.total_dy), $signed(got.total_dy));
      compare_field("packet_count", want.packet_count, got.packet_count);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_idx;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               cmd;
  logic [3:0]         slot;
  logic [11:0]        pos_x;
  logic [11:0]        pos_y;
  logic [1:0]         path_flags;
  logic [31:0]        now_ms;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         slot_out;
  logic               pressed;
  logic               released;
  logic               down;
  logic               held;
  logic signed [13:0] delta_x;
  logic signed [13:0] delta_y;
  logic signed [17:0] total_dx;
  logic signed [17:0] total_dy;
  logic [4:0]         packet_count;
  logic               last;

  // While set, neither the sender nor the receiver idles, so the block also
  // sees stretches of back-to-back traffic.
  bit quiet;

  slot_report_scoreboard board = new();

  multitouch_slot_tracker_core #(.SLOTS(NUM_SLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
    .path_flags(path_flags), .now_ms(now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_out(slot_out), .pressed(pressed), .released(released), .down(down),
    .held(held), .delta_x(delta_x), .delta_y(delta_y),
    .total_dx(total_dx), .total_dy(total_dy),
    .packet_count(packet_count), .last(last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Both channels are observed at the rising edge. All inputs change through
  // nonblocking assignments, so the values read here are those the block
  // sampled at the same edge.
  always @(posedge clk) begin
    slot_report_t seen;
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.note_beat(cmd, slot, pos_x, pos_y, path_flags, now_ms);
      end
      if (out_valid && out_ready) begin
        seen.slot_out     = slot_out;
        seen.pressed      = pressed;
        seen.released     = released;
        seen.down         = down;
        seen.held         = held;
        seen.delta_x      = delta_x;
        seen.delta_y      = delta_y;
        seen.total_dx     = total_dx;
        seen.total_dy     = total_dy;
        seen.packet_count = packet_count;
        seen.last         = last;
        board.check_report(seen);
      end
    end
  end

  // Receiver: before each report beat it stalls for a random number of
  // cycles, then holds ready high until a beat is taken.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Sends one input beat after a random gap. Valid is left high when the
  // beat is taken, so a following beat with no gap keeps it high without a
  // second assignment in the same time step.
  task automatic send_beat(logic op, logic [3:0] s, logic [11:0] x, logic [11:0] y,
                           logic [1:0] flags, logic [31:0] now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    slot       <= s;
    pos_x      <= x;
    pos_y      <= y;
    path_flags <= flags;
    now_ms     <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lowers valid and waits until every predicted report has come back. The
  // extra cycles cover a trailing touch packet, which causes no report.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the timeout limit and then the held limit; only called while idle.
  task automatic configure(logic [15:0] timeout_val, logic [15:0] held_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_TIMEOUT;
    cfg_data <= timeout_val;
    @(posedge clk);
    board.write_reg(REG_TIMEOUT, timeout_val);
    cfg_idx  <= REG_HELD;
    cfg_data <= held_val;
    @(posedge clk);
    board.write_reg(REG_HELD, held_val);
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most beats follow well-formed finger paths (first packet,
  // a run of middle packets, then a last packet) on a handful of busy slots,
  // so the down, held and release logic is reached. The rest is noise: any
  // flags, any slot and sometimes a wild timestamp. Time mostly creeps forward
  // but now and then jumps far enough to expire slots.
  task automatic run_phase(int items, int tick_pct, bit no_gaps);
    logic [31:0] t;
    bit          active[MAX_SLOTS];
    int          roll;
    int          s;
    logic [1:0]  flags;
    quiet = no_gaps;
    t = $urandom;
    for (int k = 0; k < MAX_SLOTS; k++) active[k] = 1'b0;
    for (int i = 0; i < items; i++) begin
      t += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8000) : $urandom_range(0, 400);
      roll = $urandom_range(0, 99);
      if (roll < tick_pct) begin
        // Payload fields other than the command are don't-care on a tick.
        send_beat(CMD_TICK, 4'($urandom), 12'($urandom), 12'($urandom), 2'($urandom), t);
      end else if (roll < tick_pct + 10) begin
        send_beat(CMD_TOUCH, 4'($urandom), 12'($urandom), 12'($urandom), 2'($urandom),
                  ($urandom_range(0, 3) == 0) ? $urandom : t);
      end else begin
        s = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 15);
        if (!active[s]) begin
          flags = FLAGS_FIRST;
          active[s] = 1'b1;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 75) begin
            flags = PS_MIDDLE[1:0];
          end else if (roll < 95) begin
            flags = PS_LAST[1:0];
            active[s] = 1'b0;
          end else begin
            // First and last at once: the slot lingers until it times out.
            flags = 2'd3;
            active[s] = 1'b0;
          end
        end
        send_beat(CMD_TOUCH, 4'(s), 12'($urandom), 12'($urandom), flags, t);
      end
    end
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_idx    = REG_TIMEOUT;
    cfg_data   = '0;
    in_valid   = 1'b0;
    cmd        = CMD_TOUCH;
    slot       = '0;
    pos_x      = '0;
    pos_y      = '0;
    path_flags = '0;
    now_ms     = '0;
    quiet      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the limits still at their reset values.
    // A tick on an empty panel reports nothing but idle slots.
    send_beat(CMD_TICK, '0, '0, '0, '0, 32'd0);
    // Presses at both position extremes, a first-and-last packet, and a
    // last packet that was never pressed, which still reads as a release.
    send_beat(CMD_TOUCH, 4'd0, 12'd0, 12'd0, FLAGS_FIRST, 32'd100);
    send_beat(CMD_TOUCH, 4'd15, 12'd4095, 12'd4095, FLAGS_FIRST, 32'd100);
    send_beat(CMD_TOUCH, 4'd7, 12'd123, 12'd456, 2'd3, 32'd120);
    send_beat(CMD_TOUCH, 4'd3, 12'd0, 12'd0, PS_LAST[1:0], 32'd130);
    send_beat(CMD_TICK, '1, '1, '1, '1, 32'd150);
    // Full-scale moves in both directions.
    send_beat(CMD_TOUCH, 4'd0, 12'd4095, 12'd4095, PS_MIDDLE[1:0], 32'd200);
    send_beat(CMD_TOUCH, 4'd15, 12'd0, 12'd0, PS_MIDDLE[1:0], 32'd200);
    send_beat(CMD_TICK, '0, '0, '0, '0, 32'd250);
    // Slot 3 sat empty through the last tick, so a second last packet reads
    // as a release again; slot 0 stays down long enough to count as held.
    send_beat(CMD_TOUCH, 4'd3, 12'd10, 12'd10, PS_LAST[1:0], 32'd300);
    send_beat(CMD_TOUCH, 4'd0, 12'd4000, 12'd100, PS_MIDDLE[1:0], 32'd2300);
    send_beat(CMD_TICK, '0, '0, '0, '0, 32'd2400);
    // Idle slots 7 and 15 expire here while slot 0 is still fresh.
    send_beat(CMD_TICK, '0, '0, '0, '0, 32'd3500);
    // A path that straddles the wrap of the millisecond counter.
    send_beat(CMD_TOUCH, 4'd5, 12'd2048, 12'd2048, FLAGS_FIRST, 32'hFFFF_FF00);
    send_beat(CMD_TOUCH, 4'd5, 12'd2000, 12'd2100, PS_MIDDLE[1:0], 32'hFFFF_FFF0);
    send_beat(CMD_TICK, '0, '0, '0, '0, 32'h0000_0100);
    drain();

    // Random phases, each under its own pair of limits, the extremes included.
    // The sparse-tick phase lets the packet count run into saturation.
    configure(16'd3000, 16'd2000);
    run_phase(45, 18, 1'b0);
    configure(16'd1, 16'd0);
    run_phase(40, 18, 1'b0);
    configure(16'd65535, 16'd65535);
    run_phase(45, 18, 1'b1);
    configure(16'd65535, 16'd0);
    run_phase(50, 4, 1'b0);
    configure(16'd1, 16'd65535);
    run_phase(35, 20, 1'b0);
    configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
    run_phase(45, 18, 1'b0);
    configure(16'($urandom_range(200, 6000)), 16'($urandom_range(0, 3000)));
    run_phase(50, 15, 1'b0);
    configure(16'd500, 16'd200);
    run_phase(35, 18, 1'b1);

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS multitouch_slot_tracker_core");
    end else begin
      $display("FAIL multitouch_slot_tracker_core");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every tick with all reports
  // stalled to the maximum and every beat after its longest gap).
  initial begin
    #20_000_000;
    $display("FAIL multitouch_slot_tracker_core");
    $finish;
  end

endmodule
